// ----- rtl/rsenc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsenc_pkg
// GF(256) arithmetic and generator polynomial construction for the
// Reed-Solomon parity encoder (field polynomial x^8+x^4+x^3+x^2+1).
// ----------------------------------------------------------------------------
package rsenc_pkg;

	localparam int PARITY_COUNT_DEF = 26;
	localparam int PARITY_MAX       = 64;

	localparam logic [8:0] GF_POLY  = 9'h11D;
	localparam logic [8:0] GF_CARRY = 9'h100;
	localparam logic [7:0] GF_ALPHA = 8'd2;

	// generator coefficients, highest degree first, leading one omitted
	typedef logic [PARITY_MAX-1:0][7:0] coef_arr_t;

	// shift-and-add multiply; with one constant operand it reduces to xors
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] x;
		logic [7:0] acc;
		x   = {1'b0, a};
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				acc = acc ^ x[7:0];
			end
			x = x << 1;
			if ((x & GF_CARRY) != '0) begin
				x = x ^ GF_POLY;
			end
		end
		return acc;
	endfunction

	// product of (x + alpha^i) for i in 0..n-1, evaluated at elaboration
	function automatic coef_arr_t rs_gen(input int n);
		coef_arr_t  g;
		logic [7:0] root;
		g        = '0;
		g[n-1]   = 8'd1;
		root     = 8'd1;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				g[j] = gf_mul(g[j], root);
				if (j + 1 < n) begin
					g[j] = g[j] ^ g[j+1];
				end
			end
			root = gf_mul(root, GF_ALPHA);
		end
		return g;
	endfunction

endpackage

// ----- rtl/rs_parity_encoder_gf256.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs_parity_encoder_gf256
// Systematic Reed-Solomon parity encoder over GF(256). Data bytes are echoed
// and folded into a remainder register; the final byte of a message is
// followed by PARITY_COUNT parity bytes, highest order first.
// ----------------------------------------------------------------------------
// path: an accepted data beat passes the input register stage, then the output register
// throughput: one data beat per cycle while out_stall is low; the final byte
//   of a message also emits PARITY_COUNT parity beats, one per cycle when
//   unstalled, drained from the remainder; the input holds off for that long
// reset: arst_n clears the remainder, the drain counter and all valids
// ----------------------------------------------------------------------------
module rs_parity_encoder_gf256 #(
	parameter int PARITY_COUNT = rsenc_pkg::PARITY_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_parity,
	output logic       last_of_run
);
	import rsenc_pkg::*;

	localparam int        CW  = $clog2(PARITY_COUNT + 1);
	localparam coef_arr_t GEN = rs_gen(PARITY_COUNT);

	// input register stage (also acts as the skid slot)
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eom_s1;

	// remainder lfsr, index 0 is the highest order byte
	logic [PARITY_COUNT-1:0][7:0] rem_q;
	logic [PARITY_COUNT-1:0][7:0] rem_nxt;
	logic [PARITY_COUNT-1:0][7:0] rem_shift;
	logic [7:0]                   factor;

	// parity beats still to drain
	logic [CW-1:0] cnt_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       is_parity_q;
	logic       last_q;

	logic out_free;
	logic draining;
	logic adv;
	logic in_acc;
	logic drain_step;

	// output slot can take a new beat this cycle
	assign out_free   = !out_valid_q || !out_stall;
	assign draining   = (cnt_q != '0);
	// the held data beat moves on only when no parity is pending
	assign adv        = valid_s1 && out_free && !draining;
	assign drain_step = draining && out_free;
	assign in_stall   = valid_s1 && !adv;
	assign in_acc     = in_valid && !in_stall;

	// one lfsr step: shift toward index 0, then add factor * generator
	always_comb begin
		factor = data_s1 ^ rem_q[0];
		for (int i = 0; i < PARITY_COUNT; i++) begin
			if (i + 1 < PARITY_COUNT) begin
				rem_shift[i] = rem_q[i+1];
			end else begin
				rem_shift[i] = '0;
			end
			rem_nxt[i] = rem_shift[i] ^ gf_mul(GEN[i], factor);
		end
	end

	// control state and remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			rem_q       <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end

			if (adv) begin
				rem_q       <= rem_nxt;
				out_valid_q <= 1'b1;
				if (eom_s1) begin
					cnt_q <= CW'(PARITY_COUNT);
				end
			end else if (drain_step) begin
				// shifting in zeros leaves the remainder clear after the last beat
				rem_q       <= rem_shift;
				cnt_q       <= cnt_q - CW'(1);
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1 <= data_byte;
			eom_s1  <= end_of_message;
		end
		if (adv) begin
			out_byte_q  <= data_s1;
			is_parity_q <= 1'b0;
			last_q      <= !eom_s1;
		end else if (drain_step) begin
			out_byte_q  <= rem_q[0];
			is_parity_q <= 1'b1;
			last_q      <= (cnt_q == CW'(1));
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign is_parity   = is_parity_q;
	assign last_of_run = last_q;

	// remainder is clear while the last parity beat is offered
	a_clear_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_parity && last_of_run) |->
		(rem_q == '0 && cnt_q == '0))
		else $error("remainder not cleared after parity run");

	// the echo of a final byte waits with the full parity run still pending
	a_echo_before_parity: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_parity && !last_of_run) |-> (cnt_q == CW'(PARITY_COUNT)))
		else $error("parity drain started before final echo was taken");

	// a held input beat never advances while parity is draining
	a_hold_during_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(draining && valid_s1) |=> valid_s1)
		else $error("input stage advanced during parity drain");

endmodule
